/* rtl/cmfs_pkg.sv */
package cmfs_pkg;

  localparam int DirW      = 16;
  localparam int ScaleW    = 16;
  localparam int CoordW    = 17;
  localparam int FaceW     = 3;
  localparam int NumW      = 41;
  localparam int DivW      = 33;
  localparam int QuotW     = 17;
  localparam int DivStages = QuotW;

  localparam logic [0:0] RegPlaneMode = 1'b0;
  localparam logic [0:0] RegViewScale = 1'b1;

  localparam logic [ScaleW-1:0] ViewScaleReset = 16'd256;

  localparam logic [FaceW-1:0] FaceNegZ = 3'd0;
  localparam logic [FaceW-1:0] FacePosZ = 3'd1;
  localparam logic [FaceW-1:0] FacePosY = 3'd2;
  localparam logic [FaceW-1:0] FaceNegX = 3'd3;
  localparam logic [FaceW-1:0] FaceNegY = 3'd4;
  localparam logic [FaceW-1:0] FacePosX = 3'd5;

  localparam logic [CoordW-1:0] CoordCentre = 17'd32768;
  localparam logic [CoordW-1:0] CoordOne    = 17'd65536;
  localparam logic [CoordW-1:0] CoordZero   = 17'd0;

  typedef struct packed {
    logic [FaceW-1:0] face;
    logic             zdiv;
    logic             u_lo;
    logic             u_hi;
    logic             v_lo;
    logic             v_hi;
  } cmfs_side_t;

endpackage

/* rtl/cmfs_div_pipe.sv */
module cmfs_div_pipe
  import cmfs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  cmfs_side_t        side_i,
  input  logic [DivW-1:0]   num_u_i,
  input  logic [DivW-1:0]   num_v_i,
  input  logic [DirW-1:0]   den_i,
  output logic              valid_o,
  output cmfs_side_t        side_o,
  output logic [QuotW-1:0]  quot_u_o,
  output logic [QuotW-1:0]  quot_v_o
);

  logic             vld_q  [DivStages];
  cmfs_side_t       side_q [DivStages];
  logic [DirW-1:0]  den_q  [DivStages];
  logic [DivW-1:0]  rem_u_q[DivStages];
  logic [DivW-1:0]  rem_v_q[DivStages];
  logic [QuotW-1:0] quo_u_q[DivStages];
  logic [QuotW-1:0] quo_v_q[DivStages];

  logic             vld_in  [DivStages];
  cmfs_side_t       side_in [DivStages];
  logic [DirW-1:0]  den_in  [DivStages];
  logic [DivW-1:0]  rem_u_in[DivStages];
  logic [DivW-1:0]  rem_v_in[DivStages];
  logic [QuotW-1:0] quo_u_in[DivStages];
  logic [QuotW-1:0] quo_v_in[DivStages];
  logic [DivW-1:0]  den_sh  [DivStages];
  logic [DivW-1:0]  rem_u_d [DivStages];
  logic [DivW-1:0]  rem_v_d [DivStages];
  logic [QuotW-1:0] quo_u_d [DivStages];
  logic [QuotW-1:0] quo_v_d [DivStages];

  // Each stage settles one quotient bit, most significant first.
  always_comb begin
    for (int k = 0; k < DivStages; k++) begin
      if (k == 0) begin
        vld_in[k]   = valid_i;
        side_in[k]  = side_i;
        den_in[k]   = den_i;
        rem_u_in[k] = num_u_i;
        rem_v_in[k] = num_v_i;
        quo_u_in[k] = '0;
        quo_v_in[k] = '0;
      end else begin
        vld_in[k]   = vld_q[k-1];
        side_in[k]  = side_q[k-1];
        den_in[k]   = den_q[k-1];
        rem_u_in[k] = rem_u_q[k-1];
        rem_v_in[k] = rem_v_q[k-1];
        quo_u_in[k] = quo_u_q[k-1];
        quo_v_in[k] = quo_v_q[k-1];
      end
      den_sh[k] = DivW'(den_in[k]) << (QuotW - 1 - k);
      if (rem_u_in[k] >= den_sh[k]) begin
        rem_u_d[k] = rem_u_in[k] - den_sh[k];
        quo_u_d[k] = {quo_u_in[k][QuotW-2:0], 1'b1};
      end else begin
        rem_u_d[k] = rem_u_in[k];
        quo_u_d[k] = {quo_u_in[k][QuotW-2:0], 1'b0};
      end
      if (rem_v_in[k] >= den_sh[k]) begin
        rem_v_d[k] = rem_v_in[k] - den_sh[k];
        quo_v_d[k] = {quo_v_in[k][QuotW-2:0], 1'b1};
      end else begin
        rem_v_d[k] = rem_v_in[k];
        quo_v_d[k] = {quo_v_in[k][QuotW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivStages; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      for (int k = 0; k < DivStages; k++) begin
        vld_q[k] <= vld_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DivStages; k++) begin
        side_q[k]  <= side_in[k];
        den_q[k]   <= den_in[k];
        rem_u_q[k] <= rem_u_d[k];
        rem_v_q[k] <= rem_v_d[k];
        quo_u_q[k] <= quo_u_d[k];
        quo_v_q[k] <= quo_v_d[k];
      end
    end
  end

  assign valid_o  = vld_q[DivStages-1];
  assign side_o   = side_q[DivStages-1];
  assign quot_u_o = quo_u_q[DivStages-1];
  assign quot_v_o = quo_v_q[DivStages-1];

endmodule

/* rtl/cube_map_face_select.sv */
// Cube map face selection with face coordinates.
// The slave stream carries one direction vector per transaction; the master
// stream returns the selected face and its u,v coordinates, with the clamped
// and zero divisor flags in tuser. Configuration is written through the plain
// write port (plane mode, view scale); the user must write it only while no
// transaction is in flight, and the block itself does not enforce this.
// An accepted input passes through the registered stages for face selection
// and the scale multiply, numerator forming and range checks, then the
// one-bit-per-stage divider and the output register. Throughput is one vector
// per cycle while the receiver does not stall. Reset clears all valid bits and
// returns plane_mode to 0 and view_scale to 1.0. When the receiver stalls, the
// whole pipeline holds in place and s_axis_tready follows m_axis_tready once
// the output register is full, so no transaction is lost or repeated.
module cube_map_face_select
  import cmfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // dir_x, dir_y, dir_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // face_index, u_coord, v_coord, zero fill
  output logic [1:0]  m_axis_tuser    // clamped, zero_divisor
);

  logic              plane_mode_q;
  logic [ScaleW-1:0] view_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_mode_q <= 1'b0;
      view_scale_q <= ViewScaleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPlaneMode: plane_mode_q <= cfg_data_i[0];
        RegViewScale: view_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  // Stage 1: face selection and scale products.
  logic signed [DirW-1:0] x, y, z;
  logic signed [DirW:0]   xe, ye, ze, ax, ay, az;
  logic signed [DirW:0]   m, cu, cv;
  logic signed [DirW+1:0] su, sv;
  logic [FaceW-1:0]       c_face;
  logic signed [32:0]     pu, pv;

  assign x  = s_axis_tdata[15:0];
  assign y  = s_axis_tdata[31:16];
  assign z  = s_axis_tdata[47:32];
  assign xe = {x[DirW-1], x};
  assign ye = {y[DirW-1], y};
  assign ze = {z[DirW-1], z};
  assign ax = xe[DirW] ? -xe : xe;
  assign ay = ye[DirW] ? -ye : ye;
  assign az = ze[DirW] ? -ze : ze;

  always_comb begin
    if (ze <= -ax && ze <= -ay) begin
      c_face = FaceNegZ; m = -ze; cu = xe;  cv = ye;
    end else if (ze >= ax && ze >= ay) begin
      c_face = FacePosZ; m = ze;  cu = xe;  cv = -ye;
    end else if (ye >= ax) begin
      c_face = FacePosY; m = ye;  cu = xe;  cv = ze;
    end else if (xe <= -ay) begin
      c_face = FaceNegX; m = -xe; cu = ye;  cv = ze;
    end else if (ye <= -ax) begin
      c_face = FaceNegY; m = -ye; cu = -xe; cv = ze;
    end else begin
      c_face = FacePosX; m = xe;  cu = -ye; cv = ze;
    end
  end

  assign su = 18'(m) + 18'(cu);
  assign sv = 18'(m) + 18'(cv);
  assign pu = $signed({1'b0, view_scale_q}) * x;
  assign pv = $signed({1'b0, view_scale_q}) * y;

  logic               s1_valid_q, s1_plane_q, s1_zdiv_q, s1_zneg_q;
  logic [FaceW-1:0]   s1_face_q;
  logic [DirW-1:0]    s1_den_q;
  logic [CoordW-1:0]  s1_su_q, s1_sv_q;
  logic signed [32:0] s1_pu_q, s1_pv_q;

  // Stage 2: numerators.
  logic signed [NumW-1:0] pu_e, pv_e, pu_n, pv_n, num_u, num_v;

  assign pu_e = NumW'(s1_pu_q);
  assign pv_e = NumW'(s1_pv_q);
  assign pu_n = s1_zneg_q ? -pu_e : pu_e;
  assign pv_n = s1_zneg_q ? pv_e : -pv_e;

  always_comb begin
    if (s1_plane_q) begin
      num_u = (pu_n <<< 7) + $signed({10'b0, s1_den_q, 15'b0});
      num_v = (pv_n <<< 7) + $signed({10'b0, s1_den_q, 15'b0});
    end else begin
      num_u = $signed({9'b0, s1_su_q, 15'b0});
      num_v = $signed({9'b0, s1_sv_q, 15'b0});
    end
  end

  logic                   s2_valid_q, s2_zdiv_q;
  logic [FaceW-1:0]       s2_face_q;
  logic [DirW-1:0]        s2_den_q;
  logic signed [NumW-1:0] s2_nu_q, s2_nv_q;

  // Stage 3: range checks against 65537 times the divisor.
  logic [DivW-1:0] lim;
  cmfs_side_t      side_d;

  assign lim = (DivW'(s2_den_q) << 16) + DivW'(s2_den_q);

  always_comb begin
    side_d.face = s2_face_q;
    side_d.zdiv = s2_zdiv_q;
    side_d.u_lo = s2_nu_q[NumW-1];
    side_d.u_hi = !s2_nu_q[NumW-1] && (s2_nu_q[NumW-2:0] >= {7'b0, lim});
    side_d.v_lo = s2_nv_q[NumW-1];
    side_d.v_hi = !s2_nv_q[NumW-1] && (s2_nv_q[NumW-2:0] >= {7'b0, lim});
  end

  logic            s3_valid_q;
  cmfs_side_t      s3_side_q;
  logic [DirW-1:0] s3_den_q;
  logic [DivW-1:0] s3_nu_q, s3_nv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s_axis_tvalid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_plane_q <= plane_mode_q;
      s1_face_q  <= plane_mode_q ? FacePosZ : c_face;
      s1_zdiv_q  <= plane_mode_q ? (z == '0) : (m <= 0);
      s1_zneg_q  <= z[DirW-1];
      s1_den_q   <= plane_mode_q ? az[DirW-1:0] : m[DirW-1:0];
      s1_su_q    <= su[CoordW-1:0];
      s1_sv_q    <= sv[CoordW-1:0];
      s1_pu_q    <= pu;
      s1_pv_q    <= pv;

      s2_face_q  <= s1_face_q;
      s2_zdiv_q  <= s1_zdiv_q;
      s2_den_q   <= s1_den_q;
      s2_nu_q    <= num_u;
      s2_nv_q    <= num_v;

      s3_side_q  <= side_d;
      s3_den_q   <= s2_den_q;
      s3_nu_q    <= s2_nu_q[DivW-1:0];
      s3_nv_q    <= s2_nv_q[DivW-1:0];
    end
  end

  logic              dv_valid;
  cmfs_side_t        dv_side;
  logic [QuotW-1:0]  dv_qu, dv_qv;

  cmfs_div_pipe u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (s3_valid_q),
    .side_i   (s3_side_q),
    .num_u_i  (s3_nu_q),
    .num_v_i  (s3_nv_q),
    .den_i    (s3_den_q),
    .valid_o  (dv_valid),
    .side_o   (dv_side),
    .quot_u_o (dv_qu),
    .quot_v_o (dv_qv)
  );

  logic [CoordW-1:0] u_d, v_d;
  logic              clamped_d;

  always_comb begin
    if (dv_side.zdiv) begin
      u_d       = CoordCentre;
      v_d       = CoordCentre;
      clamped_d = 1'b0;
    end else begin
      u_d = dv_side.u_lo ? CoordZero : (dv_side.u_hi ? CoordOne : dv_qu);
      v_d = dv_side.v_lo ? CoordZero : (dv_side.v_hi ? CoordOne : dv_qv);
      clamped_d = dv_side.u_lo | dv_side.u_hi | dv_side.v_lo | dv_side.v_hi;
    end
  end

  logic [FaceW-1:0]  out_face_q;
  logic [CoordW-1:0] out_u_q, out_v_q;
  logic              out_clamped_q, out_zdiv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_face_q    <= dv_side.face;
      out_u_q       <= u_d;
      out_v_q       <= v_d;
      out_clamped_q <= clamped_d;
      out_zdiv_q    <= dv_side.zdiv;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b0, out_v_q, out_u_q, out_face_q};
  assign m_axis_tuser  = {out_zdiv_q, out_clamped_q};

endmodule

/* tb/tb_cube_map_face_select.sv */
`timescale 1ns / 1ps

module tb_cube_map_face_select;
  import cmfs_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int LongHoldAt = 150;
  localparam int LongHoldLen = 300;
  localparam int DrainAt = 300;

  typedef struct packed {
    logic signed [DirW-1:0] z;
    logic signed [DirW-1:0] y;
    logic signed [DirW-1:0] x;
  } dir_t;

  typedef struct packed {
    logic              zdiv;
    logic              clamped;
    logic [CoordW-1:0] v;
    logic [CoordW-1:0] u;
    logic [FaceW-1:0]  face;
  } face_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = RegPlaneMode;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  logic              plane_mode_q = 1'b0;
  logic [ScaleW-1:0] view_scale_q = ViewScaleReset;

  dir_t      dir_pending[$];
  face_res_t face_expect[$];
  dir_t      cur_dir;

  int          mismatches = 0;
  int          sent_count = 0;
  int          rx_count = 0;
  int          cycle_count = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  logic        drain_wait = 1'b0;
  logic        drained_once = 1'b0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  logic [15:0] rx_pat = 16'hFFFF;
  logic [3:0]  rx_pos = '0;

  cube_map_face_select u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint floor_div(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [CoordW-1:0] clip_coord(longint q);
    if (q < 0) return CoordZero;
    if (q > 65536) return CoordOne;
    return q[CoordW-1:0];
  endfunction

  function automatic face_res_t predict_face(dir_t d);
    face_res_t r;
    longint x, y, z, ax, ay, m, cu, cv, nu, nv, den, qu, qv, s;
    x = d.x;
    y = d.y;
    z = d.z;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    r.face = FacePosZ;
    r.zdiv = 1'b0;
    r.clamped = 1'b0;
    r.u = CoordCentre;
    r.v = CoordCentre;
    nu = 0;
    nv = 0;
    den = 0;
    if (plane_mode_q) begin
      if (z != 0) begin
        s = longint'(view_scale_q);
        nu = 128 * s * x + 32768 * z;
        nv = -128 * s * y + 32768 * z;
        den = z;
        if (den < 0) begin
          den = -den;
          nu = -nu;
          nv = -nv;
        end
      end
    end else begin
      if (z <= -ax && z <= -ay) begin
        r.face = FaceNegZ; m = -z; cu = x; cv = y;
      end else if (z >= ax && z >= ay) begin
        r.face = FacePosZ; m = z; cu = x; cv = -y;
      end else if (y >= ax) begin
        r.face = FacePosY; m = y; cu = x; cv = z;
      end else if (x <= -ay) begin
        r.face = FaceNegX; m = -x; cu = y; cv = z;
      end else if (y <= -ax) begin
        r.face = FaceNegY; m = -y; cu = -x; cv = z;
      end else begin
        r.face = FacePosX; m = x; cu = -y; cv = z;
      end
      if (m > 0) begin
        den = m;
        nu = 32768 * (m + cu);
        nv = 32768 * (m + cv);
      end
    end
    if (den == 0) begin
      r.zdiv = 1'b1;
    end else begin
      qu = floor_div(nu, den);
      qv = floor_div(nv, den);
      r.clamped = (qu < 0) || (qu > 65536) || (qv < 0) || (qv > 65536);
      r.u = clip_coord(qu);
      r.v = clip_coord(qv);
    end
    return r;
  endfunction

  function automatic logic [DirW-1:0] signed_pick(int unsigned mag);
    return ($urandom_range(0, 1) != 0) ? DirW'(-int'(mag)) : DirW'(mag);
  endfunction

  function automatic dir_t cube_dir();
    dir_t d;
    int unsigned kind, mag;
    kind = $urandom_range(0, 7);
    d.x = DirW'($urandom);
    d.y = DirW'($urandom);
    d.z = DirW'($urandom);
    if (kind == 0) begin
      d.x = DirW'(int'($urandom_range(0, 8)) - 4);
      d.y = DirW'(int'($urandom_range(0, 8)) - 4);
      d.z = DirW'(int'($urandom_range(0, 8)) - 4);
    end else if (kind == 1) begin
      mag = $urandom_range(0, 32768);
      d.x = signed_pick(mag);
      d.y = signed_pick(mag);
      if ($urandom_range(0, 1) != 0) d.z = signed_pick(mag);
    end
    return d;
  endfunction

  function automatic dir_t plane_dir();
    dir_t d;
    int unsigned kind;
    longint az, lim;
    kind = $urandom_range(0, 9);
    d.x = DirW'($urandom);
    d.y = DirW'($urandom);
    d.z = DirW'($urandom);
    if (kind == 0) begin
      d.z = '0;
    end else if (kind < 6) begin
      az = (d.z < 0) ? -longint'(d.z) : longint'(d.z);
      lim = (256 * az) / ((view_scale_q == 0) ? 1 : longint'(view_scale_q));
      if (lim > 32767) lim = 32767;
      d.x = DirW'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
      d.y = DirW'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
    end
    return d;
  endfunction

  task automatic add_dir(input int x, input int y, input int z);
    dir_t d;
    d.x = DirW'(x);
    d.y = DirW'(y);
    d.z = DirW'(z);
    dir_pending.push_back(d);
  endtask

  task automatic add_random(input int n);
    repeat (n) begin
      if (plane_mode_q) dir_pending.push_back(plane_dir());
      else dir_pending.push_back(cube_dir());
    end
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegPlaneMode) plane_mode_q = val[0];
    else view_scale_q = val;
  endtask

  task automatic wait_idle();
    while (dir_pending.size() != 0 || s_axis_tvalid || face_expect.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    dir_t d;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        face_expect.push_back(predict_face(cur_dir));
        sent_count <= sent_count + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (drain_wait) begin
          s_axis_tvalid <= 1'b0;
          if (face_expect.size() == 0) begin
            drain_wait <= 1'b0;
            drained_once <= 1'b1;
          end else if (hold_left != 0) begin
            drain_wait <= 1'b0;
          end
        end else if (gap_left != 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (dir_pending.size() != 0) begin
          d = dir_pending.pop_front();
          cur_dir <= d;
          s_axis_tdata <= d;
          s_axis_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 32);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if ((sent_count >= DrainAt && !drained_once) || $urandom_range(0, 15) == 0) begin
              drain_wait <= 1'b1;
            end
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a random ready pattern, with one long hold-off to back up the pipeline.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && rx_count >= LongHoldAt) begin
      hold_left <= LongHoldLen;
      hold_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rx_pat[rx_pos];
      rx_pos <= rx_pos + 1'b1;
      if (rx_pos == 4'hF) rx_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    end
  end

  always @(posedge clk_i) begin
    face_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[36:0]};
      rx_count <= rx_count + 1;
      if (face_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected transaction: face %0d u %0d v %0d clamped %0b zdiv %0b",
                   got.face, got.u, got.v, got.clamped, got.zdiv);
      end else begin
        want = face_expect.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected face %0d u %0d v %0d clamped %0b zdiv %0b, %s",
                     want.face, want.u, want.v, want.clamped, want.zdiv,
                     $sformatf("got face %0d u %0d v %0d clamped %0b zdiv %0b",
                               got.face, got.u, got.v, got.clamped, got.zdiv));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(RegPlaneMode, 16'd0);
    add_dir(0, 0, 0);
    add_dir(0, 0, -16384);
    add_dir(0, 0, 16384);
    add_dir(0, 16384, 0);
    add_dir(-16384, 0, 0);
    add_dir(0, -16384, 0);
    add_dir(16384, 0, 0);
    add_dir(16384, 16384, 16384);
    add_dir(-16384, -16384, -16384);
    add_dir(16384, 16384, 0);
    add_dir(-16384, -16384, 0);
    add_dir(-32768, -32768, -32768);
    add_dir(32767, 32767, 32767);
    add_dir(-32768, 32767, 0);
    add_dir(32767, -32768, 5);
    add_dir(-32768, 0, 0);
    add_dir(1, 1, 3);
    add_dir(-1, -1, 3);
    add_dir(5, -7, -3);
    add_random(250);
    wait_idle();

    write_reg(RegPlaneMode, 16'd1);
    write_reg(RegViewScale, ViewScaleReset);
    add_dir(5, 7, 0);
    add_dir(0, 0, 1);
    add_dir(1, 1, 3);
    add_dir(1, -1, -3);
    add_dir(32767, 32767, 1);
    add_dir(-32768, -32768, 1);
    add_dir(-32768, -32768, -1);
    add_dir(32767, 32767, 32767);
    add_dir(-32768, 32767, -32768);
    add_random(100);
    wait_idle();

    write_reg(RegViewScale, 16'd0);
    add_random(50);
    wait_idle();

    write_reg(RegViewScale, 16'hFFFF);
    add_random(80);
    wait_idle();

    write_reg(RegViewScale, 16'($urandom));
    add_random(80);
    wait_idle();

    write_reg(RegPlaneMode, 16'd0);
    add_random(60);
    wait_idle();

    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && face_expect.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
